@@ design/assert_macros.svh @@
// Assertion macros shared by the persistence blend RTL.
// Clocked property checks with an active-low asynchronous reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

@@ design/fptb_pkg.sv @@
// Package for the frame persistence trails blend: widths, constants, types.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package fptb_pkg;

	localparam int CH_W       = 16;
	localparam int NUM_CH     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CH_W:0]   Q16_ONE     = {1'b1, {CH_W{1'b0}}};
	localparam logic [CH_W-1:0] Q16_HALF    = {1'b1, {(CH_W-1){1'b0}}};
	localparam logic [CH_W-1:0] PERSIST_MAX = 16'd64225;

	localparam logic CMD_FRAME_START = 1'b0;
	localparam logic CMD_PIXEL       = 1'b1;

	localparam logic [CH_W-1:0] RST_BASE_PERSIST = 16'd52429;
	localparam logic [CH_W-1:0] RST_BEAT_FLASH   = 16'd0;
	localparam logic [CH_W-1:0] RST_FLASH_DECAY  = 16'd32768;
	localparam logic            RST_PHOSPHOR     = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_PERSIST = 2'd0,
		CFG_BEAT_FLASH   = 2'd1,
		CFG_FLASH_DECAY  = 2'd2,
		CFG_PHOSPHOR     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] base_persist;
		logic [CH_W-1:0] beat_flash;
		logic [CH_W-1:0] flash_decay;
		logic            phosphor;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]             persist;
		logic [NUM_CH-1:0][CH_W-1:0] cur;
		logic [NUM_CH-1:0][CH_W-1:0] prev;
	} pix_t;

endpackage

`default_nettype wire

@@ design/fptb_stream_if.sv @@
// Valid/ready channel interfaces for pixel items in and blended pixels out.
// Depends on fptb_pkg for the channel width.
`default_nettype none

interface fptb_in_if;
	import fptb_pkg::*;
	logic            valid;
	logic            ready;
	logic            command;
	logic            beat;
	logic [CH_W-1:0] cur_red;
	logic [CH_W-1:0] cur_green;
	logic [CH_W-1:0] cur_blue;
	logic [CH_W-1:0] prev_red;
	logic [CH_W-1:0] prev_green;
	logic [CH_W-1:0] prev_blue;

	modport source (output valid, command, beat, cur_red, cur_green, cur_blue,
		prev_red, prev_green, prev_blue, input ready);
	modport sink (input valid, command, beat, cur_red, cur_green, cur_blue,
		prev_red, prev_green, prev_blue, output ready);
endinterface

interface fptb_out_if;
	import fptb_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

@@ design/fptb_front.sv @@
// Front end: accepts items, runs the frame-start flash and persistence update,
// and pushes pixel items tagged with their persistence. Depends on fptb_pkg.
`default_nettype none

module fptb_front (
	input  logic           clk,
	input  logic           arst_n,
	fptb_in_if.sink        in_chan,
	input  fptb_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           push,
	output fptb_pkg::pix_t push_data
);
	import fptb_pkg::*;

	logic [CH_W-1:0]   flash_q;
	logic [CH_W-1:0]   persist_q;
	logic [CH_W-1:0]   flash_sel;
	logic [CH_W-1:0]   flash_next;
	logic [CH_W-1:0]   persist_next;
	logic [2*CH_W-1:0] flash_prod;
	logic              accept;

	assign in_chan.ready = !q_full;
	assign accept        = in_chan.valid && in_chan.ready;

	always_comb begin
		flash_sel  = in_chan.beat ? cfg.beat_flash : flash_q;
		flash_prod = flash_sel * cfg.flash_decay + (2*CH_W)'(Q16_HALF);
		flash_next = flash_prod[2*CH_W-1:CH_W];
		if (cfg.base_persist > flash_next) begin
			persist_next = cfg.base_persist - flash_next;
			if (persist_next > PERSIST_MAX) begin
				persist_next = PERSIST_MAX;
			end
		end else begin
			persist_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_q   <= '0;
			persist_q <= '0;
		end else if (accept && in_chan.command == CMD_FRAME_START) begin
			flash_q   <= flash_next;
			persist_q <= persist_next;
		end
	end

	assign push              = accept && in_chan.command == CMD_PIXEL;
	assign push_data.persist = persist_q;
	assign push_data.cur     = {in_chan.cur_blue, in_chan.cur_green, in_chan.cur_red};
	assign push_data.prev    = {in_chan.prev_blue, in_chan.prev_green, in_chan.prev_red};

endmodule

`default_nettype wire

@@ design/fptb_queue.sv @@
// Short register queue between front and back end of the blend.
// Holds tagged pixel items; depends on fptb_pkg for depth and entry type.
`default_nettype none

module fptb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fptb_pkg::pix_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output fptb_pkg::pix_t head
);
	import fptb_pkg::*;

	pix_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/fptb_back.sv @@
// Back end: two-stage blend pipeline per channel, products then round and
// select, ending in the output register. Depends on fptb_pkg.
`default_nettype none

module fptb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fptb_pkg::cfg_t cfg,
	input  logic           head_valid,
	input  fptb_pkg::pix_t head,
	output logic           pop,
	fptb_out_if.source     out_chan
);
	import fptb_pkg::*;

	logic                          v_s1;
	logic [NUM_CH-1:0][2*CH_W:0]   cp_s1;
	logic [NUM_CH-1:0][2*CH_W-1:0] pp_s1;
	logic [NUM_CH-1:0][CH_W-1:0]   cur_s1;
	logic                          v_s2;
	logic [NUM_CH-1:0][CH_W-1:0]   out_s2;

	logic                          adv1;
	logic                          adv2;
	logic [CH_W:0]                 inv_p;
	logic [NUM_CH-1:0][2*CH_W:0]   cp_d;
	logic [NUM_CH-1:0][2*CH_W-1:0] pp_d;
	logic [NUM_CH-1:0][2*CH_W+1:0] mix_sum;
	logic [NUM_CH-1:0][2*CH_W:0]   dec_sum;
	logic [NUM_CH-1:0][CH_W-1:0]   blend;

	assign adv2 = !v_s2 || out_chan.ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = head_valid && adv1;

	always_comb begin
		inv_p = Q16_ONE - {1'b0, head.persist};
		for (int c = 0; c < NUM_CH; c++) begin
			cp_d[c] = head.cur[c] * inv_p;
			pp_d[c] = head.prev[c] * head.persist;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			mix_sum[c] = {1'b0, cp_s1[c]} + {2'b00, pp_s1[c]} + (2*CH_W+2)'(Q16_HALF);
			dec_sum[c] = {1'b0, pp_s1[c]} + (2*CH_W+1)'(Q16_HALF);
			if (cfg.phosphor) begin
				blend[c] = (cur_s1[c] > dec_sum[c][2*CH_W-1:CH_W]) ?
					cur_s1[c] : dec_sum[c][2*CH_W-1:CH_W];
			end else begin
				blend[c] = mix_sum[c][2*CH_W-1:CH_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= head_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cp_s1  <= cp_d;
			pp_s1  <= pp_d;
			cur_s1 <= head.cur;
		end
		if (adv2 && v_s1) begin
			out_s2 <= blend;
		end
	end

	assign out_chan.valid     = v_s2;
	assign out_chan.out_red   = out_s2[0];
	assign out_chan.out_green = out_s2[1];
	assign out_chan.out_blue  = out_s2[2];

endmodule

`default_nettype wire

@@ design/frame_persistence_trails_blend.sv @@
// Frame persistence trails blend, top level: configuration registers,
// front end, queue and blend pipeline. Depends on fptb_pkg, fptb_stream_if.
//
// Usage:
//   in_chan carries frame-start items (command 0, beat flag) and pixel pairs
//   (command 1, current and previous RGB, Q0.16). out_chan carries one blended
//   RGB pixel per pixel pair; a frame start produces no transfer.
//   Throughput is one item per cycle on both channels while out_chan does not stall.
//   A pixel passes from the queue into the multiply stage registers, then
//   through the round and select logic into the output register, which
//   drives it onto out_chan.
//   A frame start updates the flash level and persistence in its own cycle,
//   so a pixel may follow it on the very next cycle.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   Reset loads the register defaults and clears flash level and persistence
//   to zero, so pixels before the first frame start pass unchanged.
//   When out_chan stalls, the output register holds, the pipeline stops and
//   the four-entry queue fills; in_chan.ready drops once the queue is full.
`default_nettype none
`include "assert_macros.svh"

module frame_persistence_trails_blend (
	input  logic                                clk,
	input  logic                                arst_n,
	fptb_in_if.sink                             in_chan,
	fptb_out_if.source                          out_chan,
	input  logic                                cfg_we,
	input  logic [fptb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fptb_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fptb_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	pix_t q_in;
	pix_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_persist <= RST_BASE_PERSIST;
			cfg_q.beat_flash   <= RST_BEAT_FLASH;
			cfg_q.flash_decay  <= RST_FLASH_DECAY;
			cfg_q.phosphor     <= RST_PHOSPHOR;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BASE_PERSIST: cfg_q.base_persist <= cfg_data[CH_W-1:0];
				CFG_BEAT_FLASH:   cfg_q.beat_flash   <= cfg_data[CH_W-1:0];
				CFG_FLASH_DECAY:  cfg_q.flash_decay  <= cfg_data[CH_W-1:0];
				CFG_PHOSPHOR:     cfg_q.phosphor     <= cfg_data[0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	fptb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_chan   (in_chan),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_in)
	);

	fptb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	fptb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_chan   (out_chan)
	);

	`ASSERT_CLK(a_persist_clamped, clk, arst_n, q_valid |-> q_head.persist <= PERSIST_MAX, "queued persistence above clamp")
	`ASSERT_NEVER(a_pop_when_empty, clk, arst_n, q_pop && !q_valid, "queue popped while empty")
	`ASSERT_CLK(a_push_reaches_head, clk, arst_n, q_push && !q_valid |=> q_valid, "pushed pixel missing at queue head")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for frame_persistence_trails_blend: frame starts and pixel pairs
// are driven on in_chan, and each blended pixel is checked against an in-bench predictor.
// Depends on fptb_pkg, fptb_stream_if and the block's RTL.

module tb_top;
	import fptb_pkg::*;

	typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1860;
	localparam int NUM_PHASES   = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD    = 120;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fptb_in_if  in_chan();
	fptb_out_if out_chan();

	frame_persistence_trails_blend DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_chan  (in_chan),
		.out_chan (out_chan),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [CH_W-1:0] base_reg     = RST_BASE_PERSIST;
	logic [CH_W-1:0] flash_reg    = RST_BEAT_FLASH;
	logic [CH_W-1:0] decay_reg    = RST_FLASH_DECAY;
	logic            phosphor_reg = RST_PHOSPHOR;
	logic [CH_W-1:0] flash_now    = '0;
	logic [CH_W-1:0] persist_now  = '0;

	rgb_t  blended_q[$];
	string chan_names[NUM_CH] = '{"red", "green", "blue"};

	int n_checked = 0;
	int n_errors = 0;
	int n_in_stalls = 0;
	int n_frames = 0;
	int n_pixels_sent = 0;
	int n_settings = 0;
	int cycles = 0;

	bit tx_gap_en = 1'b0;
	bit rx_stall_en = 1'b0;
	int n_hold_reqs = 0;
	int n_holds_done = 0;
	int rx_hold = 0;
	int rx_stall_left = 0;

	function automatic logic [CH_W-1:0] q16_mul(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
		logic [2*CH_W:0] wa;
		logic [2*CH_W:0] wb;
		logic [2*CH_W:0] prod;
		wa = a;
		wb = b;
		prod = wa * wb + Q16_HALF;
		return prod[2*CH_W-1:CH_W];
	endfunction

	function automatic rgb_t blend_pixel(input rgb_t cur, input rgb_t prev);
		rgb_t            res;
		logic [CH_W-1:0] decayed;
		logic [47:0]     c;
		logic [47:0]     pv;
		logic [47:0]     w;
		logic [47:0]     acc;
		for (int j = 0; j < NUM_CH; j++) begin
			if (persist_now == '0) begin
				res[j] = cur[j];
			end else if (phosphor_reg) begin
				decayed = q16_mul(prev[j], persist_now);
				res[j] = (cur[j] > decayed) ? cur[j] : decayed;
			end else begin
				c = cur[j];
				pv = prev[j];
				w = persist_now;
				acc = c * (Q16_ONE - w) + pv * w + Q16_HALF;
				res[j] = acc[2*CH_W-1:CH_W];
			end
		end
		return res;
	endfunction

	function automatic void start_frame(input logic beat);
		logic [CH_W-1:0] diff;
		if (beat)
			flash_now = flash_reg;
		flash_now = q16_mul(flash_now, decay_reg);
		if (base_reg > flash_now) begin
			diff = base_reg - flash_now;
			persist_now = (diff > PERSIST_MAX) ? PERSIST_MAX : diff;
		end else begin
			persist_now = '0;
		end
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return CH_W'($urandom_range(0, 255));
			3: return CH_W'($urandom_range(65280, 65535));
			default: return CH_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic rgb_t rand_rgb();
		rgb_t v;
		for (int j = 0; j < NUM_CH; j++)
			v[j] = rand_chan();
		return v;
	endfunction

	function automatic logic [CH_W-1:0] pick_setting();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return CH_W'($urandom_range(60000, 65535));
			default: return CH_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic rgb_t fill(input logic [CH_W-1:0] v);
		return {v, v, v};
	endfunction

	// receiver: long hold-off first, then random stalls
	always @(posedge clk) begin
		if (n_holds_done != n_hold_reqs) begin
			out_chan.ready <= 1'b0;
			rx_hold <= LONG_HOLD;
			n_holds_done <= n_holds_done + 1;
		end else if (rx_hold > 0) begin
			out_chan.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_stall_left > 0) begin
			out_chan.ready <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else if (rx_stall_en && $urandom_range(0, 99) < 25) begin
			out_chan.ready <= 1'b0;
			rx_stall_left <= idle_len();
		end else begin
			out_chan.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rgb_t want;
		rgb_t got;
		if (arst_n && in_chan.valid && !in_chan.ready)
			n_in_stalls++;
		if (arst_n && out_chan.valid && out_chan.ready) begin
			got = {out_chan.out_blue, out_chan.out_green, out_chan.out_red};
			if (blended_q.size() == 0) begin
				$display("%0t unexpected transfer: expected none actual %h %h %h", $time,
					got[0], got[1], got[2]);
				n_errors++;
			end else begin
				want = blended_q.pop_front();
				for (int j = 0; j < NUM_CH; j++) begin
					if (got[j] !== want[j]) begin
						$display("%0t %s mismatch: expected %h actual %h", $time,
							chan_names[j], want[j], got[j]);
						n_errors++;
					end
				end
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, blended_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic beat, input rgb_t cur, input rgb_t prev);
		int gap;
		gap = tx_gap_en ? idle_len() : 0;
		if (gap > 0) begin
			in_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_chan.valid      <= 1'b1;
		in_chan.command    <= cmd;
		in_chan.beat       <= beat;
		in_chan.cur_red    <= cur[0];
		in_chan.cur_green  <= cur[1];
		in_chan.cur_blue   <= cur[2];
		in_chan.prev_red   <= prev[0];
		in_chan.prev_green <= prev[1];
		in_chan.prev_blue  <= prev[2];
		do @(posedge clk); while (!in_chan.ready);
		if (cmd == CMD_PIXEL) begin
			blended_q.insert(blended_q.size(), blend_pixel(cur, prev));
			n_pixels_sent++;
		end else begin
			start_frame(beat);
			n_frames++;
		end
	endtask

	task automatic settle();
		in_chan.valid <= 1'b0;
		while (blended_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [CH_W-1:0] base, input logic [CH_W-1:0] flash,
		input logic [CH_W-1:0] decay, input logic [CFG_DATA_W-1:0] mode_word);
		settle();
		write_reg(CFG_BASE_PERSIST, base);
		write_reg(CFG_BEAT_FLASH, flash);
		write_reg(CFG_FLASH_DECAY, decay);
		write_reg(CFG_PHOSPHOR, mode_word);
		cfg_we <= 1'b0;
		base_reg = base;
		flash_reg = flash;
		decay_reg = decay;
		phosphor_reg = mode_word[0];
		n_settings++;
	endtask

	// pixels ahead of the first frame start pass through
	task automatic test_passthrough();
		send_item(CMD_PIXEL, 1'b0, fill('0), fill('1));
		send_item(CMD_PIXEL, 1'b1, fill('1), fill('0));
		send_item(CMD_PIXEL, 1'b0, {16'h8001, 16'h7FFE, 16'h0001}, {16'hFFFF, 16'h1234, 16'h0000});
	endtask

	task automatic test_crossfade();
		send_item(CMD_FRAME_START, 1'b0, rand_rgb(), rand_rgb());
		send_item(CMD_PIXEL, 1'b0, fill('0), fill('1));
		send_item(CMD_PIXEL, 1'b0, fill('1), fill('0));
		send_item(CMD_PIXEL, 1'b0, fill('1), fill('1));
		apply_settings('1, RST_BEAT_FLASH, RST_FLASH_DECAY, 16'h0000);
		send_item(CMD_FRAME_START, 1'b0, rand_rgb(), rand_rgb());
		send_item(CMD_PIXEL, 1'b0, fill('0), fill('1));
		send_item(CMD_PIXEL, 1'b0, {16'h0001, 16'h8000, 16'hFFFE}, {16'hFFFF, 16'h7FFF, 16'h0002});
	endtask

	task automatic test_phosphor();
		apply_settings('1, '0, RST_FLASH_DECAY, 16'h0001);
		send_item(CMD_FRAME_START, 1'b1, rand_rgb(), rand_rgb());
		send_item(CMD_PIXEL, 1'b0, fill('0), fill('1));
		send_item(CMD_PIXEL, 1'b0, fill('1), fill('1));
		send_item(CMD_PIXEL, 1'b0, {16'h8000, 16'h0001, 16'hFAE0}, {16'h9000, 16'hFFFF, 16'hFFFF});
	endtask

	// flash on a beat drives persistence to zero; decay of zero clears the flash
	task automatic test_beat_flash();
		apply_settings(RST_BASE_PERSIST, '1, '1, 16'h0000);
		send_item(CMD_FRAME_START, 1'b1, rand_rgb(), rand_rgb());
		send_item(CMD_PIXEL, 1'b0, rand_rgb(), rand_rgb());
		send_item(CMD_FRAME_START, 1'b0, rand_rgb(), rand_rgb());
		send_item(CMD_PIXEL, 1'b0, rand_rgb(), rand_rgb());
		apply_settings(RST_BASE_PERSIST, '1, '0, 16'hFFFE);
		send_item(CMD_FRAME_START, 1'b0, rand_rgb(), rand_rgb());
		send_item(CMD_PIXEL, 1'b1, rand_rgb(), rand_rgb());
		apply_settings('0, 16'd1000, RST_FLASH_DECAY, 16'h0001);
		send_item(CMD_FRAME_START, 1'b1, rand_rgb(), rand_rgb());
		send_item(CMD_PIXEL, 1'b0, rand_rgb(), rand_rgb());
	endtask

	// hold the output side off so the queue fills and in_chan stalls
	task automatic test_backpressure();
		apply_settings(16'd40000, 16'd20000, 16'd50000, 16'h0001);
		tx_gap_en = 1'b0;
		rx_stall_en = 1'b0;
		send_item(CMD_FRAME_START, 1'b1, rand_rgb(), rand_rgb());
		n_hold_reqs++;
		repeat (24) send_item(CMD_PIXEL, 1'($urandom_range(0, 1)), rand_rgb(), rand_rgb());
		settle();
	endtask

	task automatic test_random();
		int sent;
		int npix;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 0)
				apply_settings('0, '0, '0, CFG_DATA_W'($urandom_range(0, 65535)) | 16'h0001);
			else if (phase == 1)
				apply_settings('1, '1, '1, CFG_DATA_W'($urandom_range(0, 65535)) & 16'hFFFE);
			else
				apply_settings(pick_setting(), pick_setting(), pick_setting(),
					CFG_DATA_W'($urandom_range(0, 65535)));
			sent = 0;
			while (sent < RANDOM_ITEMS / NUM_PHASES) begin
				tx_gap_en = ($urandom_range(0, 3) != 0);
				rx_stall_en = ($urandom_range(0, 3) != 0);
				send_item(CMD_FRAME_START, $urandom_range(0, 2) == 0, rand_rgb(), rand_rgb());
				npix = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
				repeat (npix)
					send_item(CMD_PIXEL, 1'($urandom_range(0, 1)), rand_rgb(), rand_rgb());
				sent += npix + 1;
			end
		end
		tx_gap_en = 1'b0;
		rx_stall_en = 1'b0;
	endtask

	initial begin
		in_chan.valid      = 1'b0;
		in_chan.command    = CMD_FRAME_START;
		in_chan.beat       = 1'b0;
		in_chan.cur_red    = '0;
		in_chan.cur_green  = '0;
		in_chan.cur_blue   = '0;
		in_chan.prev_red   = '0;
		in_chan.prev_green = '0;
		in_chan.prev_blue  = '0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_BASE_PERSIST;
		cfg_data           = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_crossfade();
		test_phosphor();
		test_beat_flash();
		test_backpressure();
		test_random();
		settle();
		$display("Covered %0d frame starts and %0d pixel pairs over %0d register settings.",
			n_frames, n_pixels_sent, n_settings);
		$display("Checked %0d blended pixels; in_chan stalled for %0d cycles.",
			n_checked, n_in_stalls);
		if (n_errors == 0 && blended_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
